@@ sv/ihex_pkg.sv @@
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants for the HEX stream decoder
// Character classes, queue geometry, result kinds and error codes.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // Depth of the token queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // ASCII codes the front end looks for.
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChNul   = 8'h00;

  // Record types.
  localparam logic [7:0] RecData = 8'h00;
  localparam logic [7:0] RecEof  = 8'h01;
  localparam logic [7:0] RecExt  = 8'h04;

  // Result kinds.
  localparam logic [1:0] KindData    = 2'd0;
  localparam logic [1:0] KindRecord  = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;
  localparam logic [1:0] KindError   = 2'd3;

  // Error codes.
  localparam logic [2:0] ErrStart = 3'd0;
  localparam logic [2:0] ErrDigit = 3'd1;
  localparam logic [2:0] ErrType  = 3'd2;
  localparam logic [2:0] ErrShort = 3'd3;
  localparam logic [2:0] ErrCsum  = 3'd4;

  // Character classes after the front end.
  typedef enum logic [2:0] {
    TOK_HEX,
    TOK_EOL,
    TOK_NUL,
    TOK_COLON,
    TOK_OTHER
  } tok_e;

  typedef struct packed {
    tok_e       cls;
    logic [3:0] nib;
  } token_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic        record_ok;
    logic [2:0]  error_code;
    logic [31:0] low_address;
    logic [32:0] byte_count;
  } result_t;

  // Classify one character and decode its hex value.
  function automatic token_t classify(input logic [7:0] c);
    token_t t;
    t.cls = TOK_OTHER;
    t.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t.cls = TOK_HEX;
      t.nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      t.cls = TOK_HEX;
      t.nib = c[3:0] + 4'd9;
    end else if (c == ChLf || c == ChCr) begin
      t.cls = TOK_EOL;
    end else if (c == ChNul) begin
      t.cls = TOK_NUL;
    end else if (c == ChColon) begin
      t.cls = TOK_COLON;
    end
    return t;
  endfunction

endpackage

@@ sv/ihex_front.sv @@
// ----------------------------------------------------------------------------
// ihex_front: character intake
// Accepts characters and turns each into a classified token for the queue.
// ----------------------------------------------------------------------------
module ihex_front (
  input  logic              in_valid_i,
  input  logic [7:0]        ch_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output ihex_pkg::token_t  push_tok_o
);
  import ihex_pkg::*;

  // A request is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Character classification and hex digit decode.
  assign push_tok_o = classify(ch_i);

endmodule

@@ sv/ihex_queue.sv @@
// ----------------------------------------------------------------------------
// ihex_queue: token queue
// A short first-in first-out store between the front and the back.
// ----------------------------------------------------------------------------
module ihex_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ihex_pkg::token_t  push_tok_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              nonempty_o,
  output ihex_pkg::token_t  head_o
);
  import ihex_pkg::*;

  token_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == QueueCntW'(QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = push_i ? QueuePtrW'((QueueCntW'(wr_q) + 1'b1) % QueueDepth) : wr_q;
    rd_d  = pop_i  ? QueuePtrW'((QueueCntW'(rd_q) + 1'b1) % QueueDepth) : rd_q;
    cnt_d = cnt_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_tok_i;
    end
  end

endmodule

@@ sv/ihex_back.sv @@
// ----------------------------------------------------------------------------
// ihex_back: record decoder
// Runs the record state machine on tokens and holds the result register.
// ----------------------------------------------------------------------------
module ihex_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  ihex_pkg::token_t   tok_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output ihex_pkg::result_t  res_o
);
  import ihex_pkg::*;

  localparam logic [3:0] PhWait   = 4'd0;
  localparam logic [3:0] PhLen    = 4'd1;
  localparam logic [3:0] PhAddrHi = 4'd2;
  localparam logic [3:0] PhAddrLo = 4'd3;
  localparam logic [3:0] PhType   = 4'd4;
  localparam logic [3:0] PhData   = 4'd5;
  localparam logic [3:0] PhCsum   = 4'd6;
  localparam logic [3:0] PhTail   = 4'd7;

  logic [3:0]  phase_q, phase_d;
  logic        nib_cnt_q, nib_cnt_d;
  logic [3:0]  hi_nib_q, hi_nib_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  addr_hi_q, addr_hi_d;
  logic        is_data_q, is_data_d;
  logic        is_ext_q, is_ext_d;
  logic [7:0]  done_q, done_d;
  logic [15:0] upper_q, upper_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] cur_addr_q, cur_addr_d;
  logic [31:0] low_q, low_d;
  logic [31:0] high_q, high_d;
  logic        any_q, any_d;
  logic        halted_q, halted_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  logic        has_res;

  logic [7:0]  byte_val;
  logic [7:0]  sum_new;
  logic [7:0]  done_inc;

  // The back takes a token whenever the result slot is free or draining.
  assign pop_o       = tok_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign byte_val = {hi_nib_q, tok_i.nib};
  assign sum_new  = sum_q + byte_val;
  assign done_inc = done_q + 8'd1;

  // Record decode for one token.
  always_comb begin
    phase_d    = phase_q;
    nib_cnt_d  = nib_cnt_q;
    hi_nib_d   = hi_nib_q;
    len_d      = len_q;
    addr_hi_d  = addr_hi_q;
    is_data_d  = is_data_q;
    is_ext_d   = is_ext_q;
    done_d     = done_q;
    upper_d    = upper_q;
    sum_d      = sum_q;
    cur_addr_d = cur_addr_q;
    low_d      = low_q;
    high_d     = high_q;
    any_d      = any_q;
    halted_d   = halted_q;
    has_res    = 1'b0;
    res_d      = '0;

    if (pop_o && !halted_q) begin
      if (phase_q == PhWait || phase_q == PhTail) begin
        // Between records: line ends, record start or end of input.
        unique case (tok_i.cls)
          TOK_NUL: begin
            has_res           = 1'b1;
            res_d.kind        = KindSummary;
            res_d.low_address = low_q;
            res_d.byte_count  = any_q ? ({1'b0, high_q} - {1'b0, low_q} + 33'd1) : '0;
            phase_d    = PhWait;
            nib_cnt_d  = 1'b0;
            hi_nib_d   = '0;
            len_d      = '0;
            addr_hi_d  = '0;
            is_data_d  = 1'b1;
            is_ext_d   = 1'b0;
            done_d     = '0;
            upper_d    = '0;
            sum_d      = '0;
            cur_addr_d = '0;
            low_d      = '1;
            high_d     = '0;
            any_d      = 1'b0;
          end
          TOK_EOL: begin
            phase_d = PhWait;
          end
          TOK_COLON: begin
            if (phase_q == PhWait) begin
              phase_d   = PhLen;
              nib_cnt_d = 1'b0;
              sum_d     = '0;
              len_d     = '0;
              addr_hi_d = '0;
              is_data_d = 1'b1;
              is_ext_d  = 1'b0;
              done_d    = '0;
            end
          end
          TOK_HEX, TOK_OTHER: begin
            if (phase_q == PhWait) begin
              has_res          = 1'b1;
              res_d.kind       = KindError;
              res_d.error_code = ErrStart;
              halted_d         = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        // Inside a record: only hex digits are legal.
        unique case (tok_i.cls)
          TOK_EOL, TOK_NUL: begin
            has_res          = 1'b1;
            res_d.kind       = KindError;
            res_d.error_code = ErrShort;
            halted_d         = 1'b1;
          end
          TOK_COLON, TOK_OTHER: begin
            has_res          = 1'b1;
            res_d.kind       = KindError;
            res_d.error_code = ErrDigit;
            halted_d         = 1'b1;
          end
          TOK_HEX: begin
            if (!nib_cnt_q) begin
              nib_cnt_d = 1'b1;
              hi_nib_d  = tok_i.nib;
            end else begin
              nib_cnt_d = 1'b0;
              sum_d     = sum_new;
              unique case (phase_q)
                PhLen: begin
                  len_d   = byte_val;
                  phase_d = PhAddrHi;
                end
                PhAddrHi: begin
                  addr_hi_d = byte_val;
                  phase_d   = PhAddrLo;
                end
                PhAddrLo: begin
                  // The base address has a zero low half, so no add is needed.
                  cur_addr_d = {upper_q, addr_hi_q, byte_val};
                  phase_d    = PhType;
                end
                PhType: begin
                  is_data_d = (byte_val == RecData);
                  is_ext_d  = (byte_val == RecExt);
                  done_d    = '0;
                  if (byte_val != RecData && byte_val != RecEof && byte_val != RecExt) begin
                    has_res          = 1'b1;
                    res_d.kind       = KindError;
                    res_d.error_code = ErrType;
                    halted_d         = 1'b1;
                  end else begin
                    phase_d = (len_q != 8'd0) ? PhData : PhCsum;
                  end
                end
                PhData: begin
                  if (is_data_q) begin
                    has_res         = 1'b1;
                    res_d.kind      = KindData;
                    res_d.address   = cur_addr_q;
                    res_d.data_byte = byte_val;
                    if (cur_addr_q < low_q) low_d = cur_addr_q;
                    if (cur_addr_q > high_q) high_d = cur_addr_q;
                    any_d      = 1'b1;
                    cur_addr_d = cur_addr_q + 32'd1;
                  end else if (is_ext_q) begin
                    upper_d = {upper_q[7:0], byte_val};
                  end
                  done_d = done_inc;
                  if (done_inc == len_q) begin
                    phase_d = PhCsum;
                  end
                end
                PhCsum: begin
                  has_res = 1'b1;
                  if (sum_new != 8'd0) begin
                    res_d.kind       = KindError;
                    res_d.error_code = ErrCsum;
                    halted_d         = 1'b1;
                  end else begin
                    res_d.kind      = KindRecord;
                    res_d.record_ok = 1'b1;
                    phase_d         = PhTail;
                  end
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
    end

    // Result slot: loaded on a producing token, cleared when taken.
    if (pop_o) begin
      out_valid_d = has_res;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWait;
      nib_cnt_q   <= 1'b0;
      hi_nib_q    <= '0;
      len_q       <= '0;
      addr_hi_q   <= '0;
      is_data_q   <= 1'b1;
      is_ext_q    <= 1'b0;
      done_q      <= '0;
      upper_q     <= '0;
      sum_q       <= '0;
      cur_addr_q  <= '0;
      low_q       <= '1;
      high_q      <= '0;
      any_q       <= 1'b0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      nib_cnt_q   <= nib_cnt_d;
      hi_nib_q    <= hi_nib_d;
      len_q       <= len_d;
      addr_hi_q   <= addr_hi_d;
      is_data_q   <= is_data_d;
      is_ext_q    <= is_ext_d;
      done_q      <= done_d;
      upper_q     <= upper_d;
      sum_q       <= sum_d;
      cur_addr_q  <= cur_addr_d;
      low_q       <= low_d;
      high_q      <= high_d;
      any_q       <= any_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o && has_res) begin
      res_q <= res_d;
    end
  end

endmodule

@@ sv/intel_hex_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// intel_hex_stream_decoder_core: HEX text stream decoder, top level
// Decodes data, end and extended linear address records from ASCII text.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   input   | in        | in_valid_i/in_stall_o  | ch_i
//   result  | out       | out_valid_o/out_stall_i| kind_o .. byte_count_o
//
// While the result side is not stalled, one character per cycle is sustained
// and the record state machine in the back end handles one token each cycle.
// At the earliest, a character's result reaches the outputs through the queue,
// then the result register. Reset clears the queue, the decoder state and the
// result slot. A stalled result holds the back end; the four-entry queue keeps
// taking characters until it fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
module intel_hex_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic        record_ok_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] low_address_o,
  output logic [32:0] byte_count_o
);
  import ihex_pkg::*;

  logic    q_full, q_nonempty, push, pop;
  token_t  push_tok, head_tok;
  result_t res;

  // Character intake and classification.
  ihex_front u_front (
    .in_valid_i (in_valid_i),
    .ch_i       (ch_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .push_tok_o (push_tok)
  );

  // Token queue.
  ihex_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .head_o     (head_tok)
  );

  // Record decoder and result register.
  ihex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_nonempty),
    .tok_i       (head_tok),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign kind_o        = res.kind;
  assign address_o     = res.address;
  assign data_byte_o   = res.data_byte;
  assign record_ok_o   = res.record_ok;
  assign error_code_o  = res.error_code;
  assign low_address_o = res.low_address;
  assign byte_count_o  = res.byte_count;

endmodule

@@ sim/intel_hex_stream_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// intel_hex_stream_decoder_core_tb: self-checking bench for the HEX decoder
// Feeds HEX text one character per request and checks every result in order.
// A short table of hand-written lines comes first. Some of its results are
// typed in, and the rest are predicted. Random well-formed records follow,
// with idle and stall bursts on both sides. The run closes with one randomly
// chosen fatal error and some characters that the block must ignore.
// ----------------------------------------------------------------------------
module intel_hex_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  localparam int unsigned NumRows       = 17;
  localparam int unsigned WatchdogLimit = 2000;

  // Decoder phases of the predictor.
  typedef enum logic [3:0] {
    SCAN_LINE,
    SCAN_LEN,
    SCAN_ADDR_HI,
    SCAN_ADDR_LO,
    SCAN_TYPE,
    SCAN_DATA,
    SCAN_CSUM,
    SCAN_TAIL
  } scan_phase_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  ch        = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic        record_ok;
  logic [2:0]  error_code;
  logic [31:0] low_address;
  logic [32:0] byte_count;

  intel_hex_stream_decoder_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .ch_i          (ch),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .kind_o        (kind),
    .address_o     (address),
    .data_byte_o   (data_byte),
    .record_ok_o   (record_ok),
    .error_code_o  (error_code),
    .low_address_o (low_address),
    .byte_count_o  (byte_count)
  );

  always #10 clk = ~clk;

  // Predictor state.
  scan_phase_e st_phase;
  logic        st_odd_nibble;
  logic [7:0]  st_shift;
  logic [7:0]  st_rec_len;
  logic [15:0] st_rec_addr;
  logic [7:0]  st_rec_type;
  logic [7:0]  st_done;
  logic [15:0] st_upper;
  logic [7:0]  st_sum;
  logic [31:0] st_low;
  logic [31:0] st_high;
  logic        st_any_data;
  logic        st_halted;

  // Results still owed by the block, oldest first.
  result_t     pending_results[$];
  result_t     seen_result;
  // A typed-in table value replaces the first prediction of its row.
  logic        typed_pending = 1'b0;
  result_t     typed_result;

  logic [7:0]  line_buf[$];
  int unsigned chars_taken    = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  int unsigned stall_left     = 0;
  int unsigned quiet_cycles   = 0;

  // Directed table.
  string       row_body[NumRows];
  logic        row_seal[NumRows];
  string       row_tail[NumRows];
  logic        row_typed[NumRows];
  result_t     row_want[NumRows];

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Returns {valid, value} for one ASCII hex digit of either case.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    return (v == 8'hFF) ? 5'h00 : {1'b1, v[3:0]};
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic result_t record_result();
    result_t r;
    r = '0;
    r.kind = KindRecord;
    r.record_ok = 1'b1;
    return r;
  endfunction

  function automatic result_t summary_result(input logic [31:0] low, input logic [32:0] cnt);
    result_t r;
    r = '0;
    r.kind = KindSummary;
    r.low_address = low;
    r.byte_count = cnt;
    return r;
  endfunction

  task automatic push_result(input result_t r);
    if (typed_pending) begin
      pending_results.push_back(typed_result);
      typed_pending = 1'b0;
    end else begin
      pending_results.push_back(r);
    end
  endtask

  task automatic clear_decoder();
    st_phase      = SCAN_LINE;
    st_odd_nibble = 1'b0;
    st_shift      = 8'h00;
    st_rec_len    = 8'h00;
    st_rec_addr   = 16'h0000;
    st_rec_type   = 8'h00;
    st_done       = 8'h00;
    st_upper      = 16'h0000;
    st_sum        = 8'h00;
    st_low        = 32'hFFFF_FFFF;
    st_high       = 32'h0000_0000;
    st_any_data   = 1'b0;
    st_halted     = 1'b0;
  endtask

  task automatic raise_error(input logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = KindError;
    r.error_code = code;
    st_halted = 1'b1;
    push_result(r);
  endtask

  // One complete byte of the record moves the decoder on.
  task automatic absorb_byte(input logic [7:0] b);
    result_t     r;
    logic [31:0] a;
    st_sum = st_sum + b;
    case (st_phase)
      SCAN_LEN: begin
        st_rec_len = b;
        st_phase = SCAN_ADDR_HI;
      end
      SCAN_ADDR_HI: begin
        st_rec_addr = {b, 8'h00};
        st_phase = SCAN_ADDR_LO;
      end
      SCAN_ADDR_LO: begin
        st_rec_addr[7:0] = b;
        st_phase = SCAN_TYPE;
      end
      SCAN_TYPE: begin
        st_rec_type = b;
        if (b != RecData && b != RecEof && b != RecExt) begin
          raise_error(ErrType);
        end else begin
          st_done = 8'h00;
          st_phase = (st_rec_len != 8'h00) ? SCAN_DATA : SCAN_CSUM;
        end
      end
      SCAN_DATA: begin
        if (st_rec_type == RecData) begin
          a = {st_upper, 16'h0000} + {16'h0000, st_rec_addr} + {24'h000000, st_done};
          if (a < st_low) st_low = a;
          if (a > st_high) st_high = a;
          st_any_data = 1'b1;
          r = '0;
          r.kind = KindData;
          r.address = a;
          r.data_byte = b;
          push_result(r);
        end else if (st_rec_type == RecExt) begin
          st_upper = {st_upper[7:0], b};
        end
        st_done = st_done + 8'd1;
        if (st_done == st_rec_len) st_phase = SCAN_CSUM;
      end
      default: begin
        if (st_sum != 8'h00) begin
          raise_error(ErrCsum);
        end else begin
          st_phase = SCAN_TAIL;
          push_result(record_result());
        end
      end
    endcase
  endtask

  // Predicts what one accepted character causes.
  task automatic decode_char(input logic [7:0] c);
    logic        eol;
    logic [4:0]  hn;
    logic [32:0] cnt;
    logic [31:0] low;
    eol = (c == ChLf || c == ChCr);
    if (st_halted) return;
    if (st_phase == SCAN_LINE || st_phase == SCAN_TAIL) begin
      if (c == ChNul) begin
        cnt = st_any_data ? ({1'b0, st_high} - {1'b0, st_low} + 33'd1) : 33'd0;
        low = st_low;
        clear_decoder();
        push_result(summary_result(low, cnt));
        return;
      end
      if (eol) begin
        st_phase = SCAN_LINE;
        return;
      end
      if (st_phase == SCAN_TAIL) return;
      if (c != ChColon) begin
        raise_error(ErrStart);
        return;
      end
      st_phase      = SCAN_LEN;
      st_odd_nibble = 1'b0;
      st_shift      = 8'h00;
      st_sum        = 8'h00;
      st_rec_len    = 8'h00;
      st_rec_addr   = 16'h0000;
      st_rec_type   = 8'h00;
      st_done       = 8'h00;
      return;
    end
    if (eol || c == ChNul) begin
      raise_error(ErrShort);
      return;
    end
    hn = hex_nibble(c);
    if (!hn[4]) begin
      raise_error(ErrDigit);
      return;
    end
    st_shift = {st_shift[3:0], hn[3:0]};
    if (!st_odd_nibble) begin
      st_odd_nibble = 1'b1;
      return;
    end
    st_odd_nibble = 1'b0;
    absorb_byte(st_shift);
  endtask

  // Offers one character, with an occasional idle burst first.
  task automatic send_char(input logic [7:0] c);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_char(c);
    chars_taken++;
  endtask

  task automatic send_text(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic put_hex(input logic [7:0] b);
    line_buf.push_back(hex_digit(b[7:4]));
    line_buf.push_back(hex_digit(b[3:0]));
  endtask

  // Builds the text of one record; a nonzero csum_off spoils the checksum.
  task automatic build_record(input logic [7:0] rtype, input int unsigned len,
                              input logic [15:0] addr, input logic [7:0] csum_off);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'(len) + addr[15:8] + addr[7:0] + rtype;
    line_buf.push_back(ChColon);
    put_hex(8'(len));
    put_hex(addr[15:8]);
    put_hex(addr[7:0]);
    put_hex(rtype);
    for (int unsigned i = 0; i < len; i++) begin
      if (rtype == RecExt && $urandom_range(0, 2) == 0) b = 8'hFF;
      else b = 8'($urandom_range(0, 255));
      sum = sum + b;
      put_hex(b);
    end
    put_hex(8'd0 - sum + csum_off);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    if (got.address !== want.address)
      report_mismatch($sformatf("address %h, expected %h", got.address, want.address));
    if (got.data_byte !== want.data_byte)
      report_mismatch($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
    if (got.record_ok !== want.record_ok)
      report_mismatch($sformatf("record_ok %b, expected %b", got.record_ok, want.record_ok));
    if (got.error_code !== want.error_code)
      report_mismatch($sformatf("error_code %0d, expected %0d", got.error_code,
                                want.error_code));
    if (got.low_address !== want.low_address)
      report_mismatch($sformatf("low_address %h, expected %h", got.low_address,
                                want.low_address));
    if (got.byte_count !== want.byte_count)
      report_mismatch($sformatf("byte_count %h, expected %h", got.byte_count,
                                want.byte_count));
  endtask

  // Result side: compare each accepted result, then pick the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_result.kind        = kind;
        seen_result.address     = address;
        seen_result.data_byte   = data_byte;
        seen_result.record_ok   = record_ok;
        seen_result.error_code  = error_code;
        seen_result.low_address = low_address;
        seen_result.byte_count  = byte_count;
        if (pending_results.size() == 0)
          report_mismatch($sformatf("result of kind %0d with nothing pending", kind));
        else
          check_result(seen_result, pending_results.pop_front());
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 16);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when neither side has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t ns watchdog expired", $time);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  c;
    logic [4:0]  hn;
    logic [7:0]  acc;
    logic [7:0]  sum;
    logic        odd;
    logic [7:0]  rtype;
    logic [15:0] addr;
    logic [2:0]  err_pick;
    int unsigned len;
    int unsigned k;
    int unsigned random_goal;

    clear_decoder();

    // Hand-written lines; '%' stands for a NUL character and \015 for CR.
    row_body  = '{"%", "\015\n\n\015", ":00000001", ":01FFFF00FF", ":03123400abcdef",
                  ":00000000", ":02000001AABB", ":03000004123456", ":020010001122",
                  ":02000004FFFF", ":02FFFF000011", "%", ":0100000442", ":01ABCD0099",
                  "%", ":04FFFE00DeAdBeEf", "%"};
    row_seal  = '{0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 0, 1, 0};
    row_tail  = '{"", "", "\015\n", "\n", "  x\377~\015\n", "\n", "\n", "\015\n", "\n",
                  "\n", "\n", "", "\n", "", "", "\015", ""};
    row_typed = '{1, 0, 1, 0, 0, 1, 1, 1, 0, 1, 0, 1, 1, 0, 1, 0, 0};
    row_want[0]  = summary_result(32'hFFFF_FFFF, 33'd0);
    row_want[2]  = record_result();
    row_want[5]  = record_result();
    row_want[6]  = record_result();
    row_want[7]  = record_result();
    row_want[9]  = record_result();
    // Data from 0000_0000 to FFFF_FFFF spans the whole address space.
    row_want[11] = summary_result(32'h0000_0000, 33'h1_0000_0000);
    row_want[12] = record_result();
    row_want[14] = summary_result(32'h0042_ABCD, 33'd1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines, the checksum appended where the row asks for it.
    idle_pct = 10;
    stall_pct = 10;
    for (int unsigned r = 0; r < NumRows; r++) begin
      typed_pending = row_typed[r];
      typed_result = row_want[r];
      sum = 8'h00;
      acc = 8'h00;
      odd = 1'b0;
      for (int i = 0; i < row_body[r].len(); i++) begin
        c = row_body[r].getc(i);
        if (c == "%") c = ChNul;
        send_char(c);
        hn = hex_nibble(c);
        if (hn[4]) begin
          acc = {acc[3:0], hn[3:0]};
          if (odd) sum = sum + acc;
          odd = !odd;
        end
      end
      if (row_seal[r]) begin
        put_hex(8'd0 - sum);
        send_text(line_buf.size());
      end
      for (int i = 0; i < row_tail[r].len(); i++) send_char(row_tail[r].getc(i));
    end

    // Hold the sender until everything owed has come out.
    drain_results();

    // Random well-formed records with blank lines, junk tails and summaries.
    random_goal = chars_taken + 270;
    while (chars_taken < random_goal) begin
      idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
      if ($urandom_range(0, 5) == 0) send_char(($urandom_range(0, 1) != 0) ? ChCr : ChLf);
      if ($urandom_range(0, 7) == 0) send_char(ChNul);
      k = $urandom_range(0, 19);
      if (k < 14) begin
        rtype = RecData;
        len = ($urandom_range(0, 59) == 0) ? 255 : $urandom_range(0, 16);
      end else if (k < 18) begin
        rtype = RecExt;
        len = ($urandom_range(0, 2) != 0) ? 2 : $urandom_range(0, 4);
      end else begin
        rtype = RecEof;
        len = $urandom_range(0, 2);
      end
      case ($urandom_range(0, 3))
        0: addr = 16'hFFFF - 16'($urandom_range(0, 3));
        1: addr = 16'($urandom_range(0, 3));
        default: addr = 16'($urandom_range(0, 65535));
      endcase
      build_record(rtype, len, addr, 8'h00);
      send_text(line_buf.size());
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          do c = 8'($urandom_range(1, 255)); while (c == ChLf || c == ChCr);
          send_char(c);
        end
      end
      k = $urandom_range(0, 9);
      if (k == 0) begin
        send_char(ChNul);
      end else if (k < 4) begin
        send_char(ChCr);
      end else if (k < 7) begin
        send_char(ChLf);
      end else begin
        send_char(ChCr);
        send_char(ChLf);
      end
    end

    // Closing part without idling: one fatal error, then ignored input.
    idle_pct = 0;
    stall_pct = 0;
    err_pick = 3'($urandom_range(0, 4));
    case (err_pick)
      ErrStart: begin
        send_char(ChLf);
        do c = 8'($urandom_range(0, 255));
        while (c == ChLf || c == ChCr || c == ChNul || c == ChColon);
        send_char(c);
      end
      ErrDigit: begin
        build_record(RecData, $urandom_range(0, 4), 16'($urandom_range(0, 65535)), 8'h00);
        k = $urandom_range(1, line_buf.size() - 1);
        do begin
          c = 8'($urandom_range(0, 255));
          hn = hex_nibble(c);
        end while (hn[4] || c == ChLf || c == ChCr || c == ChNul);
        line_buf[k] = c;
        send_text(k + 1);
      end
      ErrType: begin
        do rtype = 8'($urandom_range(0, 255));
        while (rtype == RecData || rtype == RecEof || rtype == RecExt);
        build_record(rtype, $urandom_range(0, 3), 16'($urandom_range(0, 65535)), 8'h00);
        send_text(line_buf.size());
      end
      ErrShort: begin
        build_record(RecData, $urandom_range(0, 4), 16'($urandom_range(0, 65535)), 8'h00);
        send_text($urandom_range(1, line_buf.size() - 1));
        k = $urandom_range(0, 2);
        send_char((k == 0) ? ChCr : ((k == 1) ? ChLf : ChNul));
      end
      default: begin
        build_record(RecData, $urandom_range(0, 8), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(1, 255)));
        send_text(line_buf.size());
      end
    endcase
    repeat (20) send_char(8'($urandom_range(0, 255)));

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
